// File: src/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg: shared types and constants for the path reference projection block
// Request/response payloads, path entry layout, widths and state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package prp_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 32;
   localparam int HEAD_W     = 16;
   localparam int IDX_W      = 10;
   localparam int LEN_W      = 11;
   localparam int ADDR_W     = $clog2(MAX_POINTS);

   // arithmetic widths
   localparam int DIFF_W = COORD_BITS + 1;       // coordinate difference
   localparam int SQR_W  = 2 * DIFF_W - 1;       // square of a difference magnitude
   localparam int SQ_W   = 2 * DIFF_W;           // sum of two squares, dot magnitude
   localparam int DOT_W  = SQ_W + 1;             // signed dot product
   localparam int PROD_W = SQ_W + DIFF_W;        // |dot| * |axis|
   localparam int NUM_W  = PROD_W + 1;           // 2*prod + den
   localparam int DEN2_W = SQ_W + 1;             // 2*den
   localparam int REM_W  = DEN2_W + 1;
   localparam int CNT_W  = $clog2(NUM_W + 1);
   localparam int SUM_W  = COORD_BITS + 2;       // nearest + offset before saturation

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type                    opcode;
      logic [IDX_W-1:0]              point_index;
      logic signed [COORD_BITS-1:0]  pos_x;
      logic signed [COORD_BITS-1:0]  pos_y;
      logic signed [HEAD_W-1:0]      point_heading;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  ref_x;
      logic signed [COORD_BITS-1:0]  ref_y;
      logic signed [HEAD_W-1:0]      ref_heading;
      logic [IDX_W-1:0]              nearest_index;
      logic                          degenerate_segment;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  x;
      logic signed [COORD_BITS-1:0]  y;
      logic signed [HEAD_W-1:0]      h;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_NEAR,
      ST_DIFF,
      ST_PROD,
      ST_DOT,
      ST_CHECK,
      ST_AXIS_X,
      ST_AXIS_Y,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

endpackage

`default_nettype wire

// File: src/prp_muldiv.sv
// ----------------------------------------------------------------------------
// prp_muldiv: sequential rounded scaling unit
// Computes min(round(a * b / den), 2^COORD_BITS) by shift-add multiply and
// restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_muldiv (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire [prp_pkg::SQ_W-1:0]     mag_a,
   input  wire [prp_pkg::DIFF_W-1:0]   mag_b,
   input  wire [prp_pkg::SQ_W-1:0]     den,
   output logic                        done,
   output logic [prp_pkg::DIFF_W-1:0]  quot
);
   import prp_pkg::*;

   md_state_type         state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [PROD_W-1:0]    mcand_ff, mcand_in;
   logic [DIFF_W-1:0]    mplier_ff, mplier_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DEN2_W-1:0]    den2_ff, den2_in;
   logic [REM_W-1:0]     rem_sh;
   logic                 q_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      num_ff    <= num_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      den2_ff   <= den2_in;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den2_in   = den2_ff;
      rem_sh    = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
      unique case (state_ff)
         MD_IDLE: begin
            if (start) begin
               acc_in    = '0;
               mcand_in  = PROD_W'(mag_a);
               mplier_in = mag_b;
               den2_in   = {den, 1'b0};
               cnt_in    = '0;
               state_in  = MD_MUL;
            end
         end
         MD_MUL: begin
            if (mplier_ff[0])
               acc_in = acc_ff + mcand_ff;
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIFF_W - 1)) begin
               // final partial product folded in here; 2*prod + den feeds the divider
               num_in   = {acc_in, 1'b0} + NUM_W'(den2_ff[DEN2_W-1:1]);
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            if (rem_sh >= REM_W'(den2_ff)) begin
               rem_in = rem_sh - REM_W'(den2_ff);
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   // clamp to 2^COORD_BITS
   assign q_sat = (|quo_ff[NUM_W-1:DIFF_W]) ||
                  (quo_ff[DIFF_W-1] && (|quo_ff[DIFF_W-2:0]));
   assign quot  = q_sat ? {1'b1, {(DIFF_W-1){1'b0}}} : quo_ff[DIFF_W-1:0];
   assign done  = done_ff;

endmodule

`default_nettype wire

// File: src/path_reference_projection_unit.sv
// ----------------------------------------------------------------------------
// path_reference_projection_unit: nearest point projection on a closed path
// Stores path points and projects a vehicle position onto the segment that starts at the nearest point.
// ----------------------------------------------------------------------------
// A write request stores one path point (x, y, heading) in the path memory. A
// query scans slots 0 to path_length-1 (a path_length of 0 counts as 1, one
// above MAX_POINTS as MAX_POINTS) through the single read port of the path
// memory, one slot per cycle, lets the scan pipeline drain, then fetches the
// nearest and next point, forms the dot product and runs the shared shift-add
// multiply / restoring divide unit once per axis; a degenerate segment skips
// the divider. The result sits in an output register, so the next request can
// be taken while it waits. The path memory has no reset; path_length resets
// to 1.
`default_nettype none

module path_reference_projection_unit (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire prp_pkg::req_type     req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output prp_pkg::rsp_type          rsp_data,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire [prp_pkg::LEN_W-1:0]  csr_data
);
   import prp_pkg::*;

   entry_type                 mem [MAX_POINTS];
   entry_type                 rdata_ff;
   logic [ADDR_W-1:0]         raddr;

   state_type                 state_ff, state_in;
   logic [LEN_W-1:0]          plen_ff, plen_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [LEN_W-1:0]          cnt_ff, cnt_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;

   // scan pipeline
   logic                      v1_ff, v1_in, v2_ff, v3_ff;
   logic [IDX_W-1:0]          i1_ff, i1_in, i2_ff, i3_ff;
   logic [DIFF_W-1:0]         mx_ff, my_ff, mx_in, my_in;
   logic [SQR_W-1:0]          sx_ff, sy_ff;
   logic [SQ_W-1:0]           best_ff, best_in, dist_sum;
   logic [IDX_W-1:0]          bi_ff, bi_in;
   logic signed [DIFF_W-1:0]  ddx, ddy;

   // projection datapath
   entry_type                 near_ff, near_in;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff, vx_ff, vy_ff;
   logic signed [DIFF_W-1:0]  dx_in, dy_in, vx_in, vy_in;
   logic signed [SQ_W-1:0]    qdx_ff, qdy_ff, pdx_ff, pdy_ff;
   logic [SQ_W-1:0]           den_ff, den_in;
   logic signed [DOT_W-1:0]   dot_ff, dot_in, dot_neg;
   logic [SQ_W-1:0]           dot_mag;
   logic                      deg_ff, deg_in;
   logic [DIFF_W-1:0]         qx_ff, qx_in;
   logic [LEN_W-1:0]          nxt_w;
   logic [ADDR_W-1:0]         nxt;

   logic                      md_start, md_done;
   logic [DIFF_W-1:0]         md_b, md_q;

   logic                      rsp_valid_ff, rsp_valid_in, rsp_load;
   rsp_type                   rsp_ff, rsp_in;
   logic signed [SUM_W-1:0]   sum_x, sum_y;
   logic signed [SUM_W-1:0]   off_x, off_y;

   logic                      req_fire, csr_fire;

   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   // path memory
   always_ff @(posedge clock) begin
      if (req_fire && req_data.opcode == OP_WRITE)
         mem[req_data.point_index[ADDR_W-1:0]] <= '{x: req_data.pos_x, y: req_data.pos_y,
                                                    h: req_data.point_heading};
      rdata_ff <= mem[raddr];
   end

   function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] d);
      mag_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   assign ddx  = $signed({rdata_ff.x[COORD_BITS-1], rdata_ff.x}) -
                 $signed({px_ff[COORD_BITS-1], px_ff});
   assign ddy  = $signed({rdata_ff.y[COORD_BITS-1], rdata_ff.y}) -
                 $signed({py_ff[COORD_BITS-1], py_ff});
   assign dist_sum = SQ_W'(sx_ff) + SQ_W'(sy_ff);

   assign nxt_w = LEN_W'(bi_ff) + 1'b1;
   assign nxt   = (nxt_w == len_ff) ? '0 : nxt_w[ADDR_W-1:0];

   assign dot_neg = -dot_ff;
   assign dot_mag = dot_ff[DOT_W-1] ? dot_neg[SQ_W-1:0] : dot_ff[SQ_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         plen_ff      <= LEN_W'(1);
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plen_ff      <= plen_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff  <= len_in;
      cnt_ff  <= cnt_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      i1_ff   <= i1_in;
      i2_ff   <= i1_ff;
      i3_ff   <= i2_ff;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      sx_ff   <= SQR_W'(mx_ff * mx_ff);
      sy_ff   <= SQR_W'(my_ff * my_ff);
      best_ff <= best_in;
      bi_ff   <= bi_in;
      near_ff <= near_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      qdx_ff  <= dx_ff * dx_ff;
      qdy_ff  <= dy_ff * dy_ff;
      pdx_ff  <= vx_ff * dx_ff;
      pdy_ff  <= vy_ff * dy_ff;
      den_ff  <= den_in;
      dot_ff  <= dot_in;
      deg_ff  <= deg_in;
      qx_ff   <= qx_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      plen_in  = csr_fire ? csr_data : plen_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      v1_in    = 1'b0;
      i1_in    = cnt_ff[IDX_W-1:0];
      mx_in    = mag_diff(ddx);
      my_in    = mag_diff(ddy);
      best_in  = best_ff;
      bi_in    = bi_ff;
      near_in  = near_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      den_in   = SQ_W'(qdx_ff) + SQ_W'(qdy_ff);
      dot_in   = DOT_W'(pdx_ff) + DOT_W'(pdy_ff);
      deg_in   = deg_ff;
      qx_in    = qx_ff;
      raddr    = cnt_ff[ADDR_W-1:0];
      md_start = 1'b0;
      md_b     = mag_diff(dx_ff);
      rsp_load = 1'b0;

      // best-distance update: slot 0 always loads, later slots only when strictly closer
      if (v3_ff && (i3_ff == '0 || dist_sum < best_ff)) begin
         best_in = dist_sum;
         bi_in   = i3_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.opcode == OP_QUERY) begin
               px_in  = req_data.pos_x;
               py_in  = req_data.pos_y;
               cnt_in = '0;
               if (plen_ff == '0)
                  len_in = LEN_W'(1);
               else if (plen_ff > LEN_W'(MAX_POINTS))
                  len_in = LEN_W'(MAX_POINTS);
               else
                  len_in = plen_ff;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != len_ff) begin
               v1_in  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            raddr    = bi_ff[ADDR_W-1:0];
            state_in = ST_NEAR;
         end
         ST_NEAR: begin
            raddr    = nxt;
            near_in  = rdata_ff;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            dx_in = $signed({rdata_ff.x[COORD_BITS-1], rdata_ff.x}) -
                    $signed({near_ff.x[COORD_BITS-1], near_ff.x});
            dy_in = $signed({rdata_ff.y[COORD_BITS-1], rdata_ff.y}) -
                    $signed({near_ff.y[COORD_BITS-1], near_ff.y});
            vx_in = $signed({px_ff[COORD_BITS-1], px_ff}) -
                    $signed({near_ff.x[COORD_BITS-1], near_ff.x});
            vy_in = $signed({py_ff[COORD_BITS-1], py_ff}) -
                    $signed({near_ff.y[COORD_BITS-1], near_ff.y});
            state_in = ST_PROD;
         end
         ST_PROD:  state_in = ST_DOT;
         ST_DOT:   state_in = ST_CHECK;
         ST_CHECK: begin
            deg_in = (den_ff == '0);
            if (den_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               md_start = 1'b1;
               state_in = ST_AXIS_X;
            end
         end
         ST_AXIS_X: begin
            if (md_done) begin
               qx_in    = md_q;
               md_start = 1'b1;
               md_b     = mag_diff(dy_ff);
               state_in = ST_AXIS_Y;
            end
         end
         ST_AXIS_Y: begin
            if (md_done)
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // the divider result for y stays in its register until the next start
   prp_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .mag_a (dot_mag),
      .mag_b (md_b),
      .den   (den_ff),
      .done  (md_done),
      .quot  (md_q)
   );

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
         input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi, lo;
      hi = SUM_W'({1'b0, {(COORD_BITS-1){1'b1}}});
      lo = ~hi;
      if (v > hi)
         sat_coord = hi[COORD_BITS-1:0];
      else if (v < lo)
         sat_coord = lo[COORD_BITS-1:0];
      else
         sat_coord = v[COORD_BITS-1:0];
   endfunction

   always_comb begin
      off_x = (dot_ff[DOT_W-1] ^ dx_ff[DIFF_W-1]) ? -$signed(SUM_W'(qx_ff))
                                                  :  $signed(SUM_W'(qx_ff));
      off_y = (dot_ff[DOT_W-1] ^ dy_ff[DIFF_W-1]) ? -$signed(SUM_W'(md_q))
                                                  :  $signed(SUM_W'(md_q));
      if (deg_ff) begin
         off_x = '0;
         off_y = '0;
      end
      sum_x = $signed({{(SUM_W-COORD_BITS){near_ff.x[COORD_BITS-1]}}, near_ff.x}) + off_x;
      sum_y = $signed({{(SUM_W-COORD_BITS){near_ff.y[COORD_BITS-1]}}, near_ff.y}) + off_y;
      rsp_in = rsp_ff;
      if (rsp_load) begin
         rsp_in.ref_x              = sat_coord(sum_x);
         rsp_in.ref_y              = sat_coord(sum_y);
         rsp_in.ref_heading        = near_ff.h;
         rsp_in.nearest_index      = bi_ff;
         rsp_in.degenerate_segment = deg_ff;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: src/prp_checker.sv
// ----------------------------------------------------------------------------
// prp_checker: port-level checks for the path reference projection unit
// Watches the request and response ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_ready,
   input wire prp_pkg::req_type     req_data,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input wire prp_pkg::rsp_type     rsp_data,
   input wire                       csr_valid,
   input wire                       csr_ready,
   input wire [prp_pkg::LEN_W-1:0]  csr_data
);
   import prp_pkg::*;

   // a pending response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // a write request never raises a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.opcode == OP_WRITE |=> !$rose(rsp_valid))
      else $error("write request produced a response");

   // a query occupies the block for at least the following cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.opcode == OP_QUERY |=> !req_ready)
      else $error("request taken while a query is in flight");

   // nothing is presented straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind path_reference_projection_unit prp_checker u_prp_checker (.*);

`default_nettype wire
